// ===== hdl/latency_compensation_planner_defines.svh =====
// Assertion macros for the latency compensation planner checker.
// Included by lcp_checker.sv; no other dependencies.
`ifndef LATENCY_COMPENSATION_PLANNER_DEFINES_SVH
`define LATENCY_COMPENSATION_PLANNER_DEFINES_SVH
// implication checked on every clock, disabled during reset
`define LCP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// implication whose consequent is checked on the next clock
`define LCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/lcp_pkg.sv =====
// Package for the latency compensation planner: item types and codes.
// No dependencies.
`timescale 1ns / 1ps
package lcp_pkg;
  localparam logic [2:0] OP_CLEAR       = 3'd0;
  localparam logic [2:0] OP_ADD_BUS     = 3'd1;
  localparam logic [2:0] OP_ADD_TRACK   = 3'd2;
  localparam logic [2:0] OP_ADD_SEND    = 3'd3;
  localparam logic [2:0] OP_FINISH      = 3'd4;
  localparam logic [2:0] OP_QUERY_BUS   = 3'd5;
  localparam logic [2:0] OP_QUERY_TRACK = 3'd6;
  localparam logic [2:0] OP_QUERY_SEND  = 3'd7;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_BAD_BUS       = 3'd1;
  localparam logic [2:0] ST_TRACK_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_SEND_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_SEND_NO_BUS   = 3'd4;
  localparam logic [2:0] ST_FULL          = 3'd5;

  typedef struct packed {
    logic [2:0]         operation;
    logic [15:0]        item_id;
    logic [15:0]        dest_bus_id;
    logic signed [23:0] latency;
    logic               enabled;
  } lcp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] issue_id;
    logic [23:0] delay;
    logic [23:0] total_latency;
    logic        to_master;
    logic        found;
  } lcp_out_t;

  // Token passed down the cell chain each scan cycle
  typedef struct packed {
    logic        live;      // scan token in flight
    logic [15:0] key;       // bus id searched (0 = none)
    logic        hit;       // match seen upstream
    logic [22:0] hit_in;    // input latency of the match
    logic [22:0] hit_plug;  // plugin latency of the match
    logic        hit_act;   // active flag of the match
    logic [23:0] max_tot;   // running max of active totals
  } lcp_tok_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic        clr;
    logic        wr_new;   // write new bus at the slot equal to bus_count
    logic        raise;    // raise bus with id raise_key
    logic [15:0] raise_key;
    logic [22:0] lat;
  } lcp_cmd_t;
endpackage

// ===== hdl/lcp_cell.sv =====
// One bus slot of the planner chain: stores id, latencies, active flag.
// Depends on lcp_pkg.
`timescale 1ns / 1ps
module lcp_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              sel,      // this slot receives a new bus
  input  logic              used,     // slot below bus count
  input  lcp_pkg::lcp_cmd_t cmd,
  input  lcp_pkg::lcp_tok_t tok_in,
  output lcp_pkg::lcp_tok_t tok_out
);
  import lcp_pkg::*;
  logic [15:0] bus_id;
  logic [22:0] plug;
  logic [22:0] in_lat;
  logic        active;
  logic [23:0] tot;
  logic        match;
  lcp_tok_t    tok_next;

  assign tot   = {1'b0, in_lat} + {1'b0, plug};
  assign match = used && (tok_in.key != 16'd0) && (bus_id == tok_in.key);

  // Hold slot contents; load on add (id from raise_key), raise on track or send
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      active <= 1'b0;
    end else if (cmd.wr_new && sel) begin
      bus_id <= cmd.raise_key;
      plug   <= cmd.lat;
      in_lat <= 23'd0;
      active <= 1'b0;
    end else if (cmd.raise && used && bus_id == cmd.raise_key) begin
      active <= 1'b1;
      if (cmd.lat > in_lat) in_lat <= cmd.lat;
    end
  end

  // Pick up the first match and fold this slot's total into the running max
  always_comb begin
    tok_next = tok_in;
    if (match && !tok_in.hit) begin
      tok_next.hit      = 1'b1;
      tok_next.hit_in   = in_lat;
      tok_next.hit_plug = plug;
      tok_next.hit_act  = active;
    end
    if (used && active && tot > tok_in.max_tot) tok_next.max_tot = tot;
  end

  // Advance the token one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.live <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end
endmodule

// ===== hdl/latency_compensation_planner.sv =====
// Top level of the latency compensation planner: sequencer and cell chain.
// Depends on lcp_pkg and lcp_cell.
`timescale 1ns / 1ps
// Channel  Handshake          Payload
// in       start / busy       item_in  (lcp_in_t)
// out      done strobe        item_out (lcp_out_t)
// Every item runs one scan token down the chain of MAX_BUSES cells, one cell
// a cycle; the item is decoded once the token has left the chain.
// A bus add or raise is then registered as a command and written in S_WRITE.
// busy drops in the done cycle, so the next item can be taken at its end.
// Reset (synchronous, rst high) empties the table at once.
// done lasts one cycle; the receiver cannot stall it.
module latency_compensation_planner #(
  parameter int MAX_BUSES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lcp_pkg::lcp_in_t   item_in,
  output logic               busy,
  output logic               done,
  output lcp_pkg::lcp_out_t  item_out
);
  import lcp_pkg::*;
  localparam int CW = $clog2(MAX_BUSES + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE} state_t;
  state_t      state;
  lcp_in_t     cur;
  lcp_in_t     item_c;
  logic [22:0] lat_c;
  logic [CW-1:0] bus_count;
  logic [22:0] direct_master;
  logic [23:0] pre_master;
  logic [22:0] track_lat;
  lcp_cmd_t    cmd;
  lcp_tok_t    tok [0:MAX_BUSES];
  lcp_tok_t    tok_head;
  lcp_tok_t    res;
  logic [23:0] hit_tot;
  lcp_out_t    out_next;
  lcp_cmd_t    cmd_next;
  logic [22:0] direct_master_next;
  logic [23:0] pre_master_next;
  logic [22:0] track_lat_next;

  assign lat_c   = item_in.latency[23] ? 23'd0 : item_in.latency[22:0];
  assign res     = tok[MAX_BUSES];
  assign busy    = (state != S_IDLE);
  assign hit_tot = {1'b0, res.hit_in} + {1'b0, res.hit_plug};

  // Clamp the latency of the incoming item
  always_comb begin
    item_c         = item_in;
    item_c.latency = {1'b0, lat_c};
  end

  // Inject the scan token on accept
  always_comb begin
    tok_head          = '0;
    tok_head.live     = start && !busy;
    tok_head.key      = (item_in.operation == OP_ADD_BUS ||
                         item_in.operation == OP_QUERY_BUS) ?
                        item_in.item_id : item_in.dest_bus_id;
    tok_head.max_tot  = {1'b0, direct_master};
  end
  assign tok[0] = tok_head;

  genvar g;
  generate
    for (g = 0; g < MAX_BUSES; g++) begin : g_cell
      lcp_cell u_cell (
        .clk(clk), .rst(rst),
        .sel(CW'(g) == bus_count),
        .used(CW'(g) < bus_count),
        .cmd(cmd),
        .tok_in(tok[g]),
        .tok_out(tok[g+1])
      );
    end
  endgenerate

  // Decode the item once its token has left the chain
  always_comb begin
    out_next           = '0;
    cmd_next           = '0;
    direct_master_next = direct_master;
    pre_master_next    = pre_master;
    track_lat_next     = track_lat;
    unique case (cur.operation)
      OP_CLEAR: begin
        cmd_next.clr       = 1'b1;
        direct_master_next = '0;
        pre_master_next    = '0;
        track_lat_next     = '0;
      end
      OP_ADD_BUS: begin
        if (cur.item_id == 16'd0 || res.hit) begin
          out_next.status   = ST_BAD_BUS;
          out_next.issue_id = cur.item_id;
        end else if (bus_count >= CW'(MAX_BUSES)) begin
          out_next.status   = ST_FULL;
          out_next.issue_id = cur.item_id;
        end else begin
          cmd_next.wr_new    = 1'b1;
          cmd_next.raise_key = cur.item_id;
          cmd_next.lat       = cur.latency[22:0];
        end
      end
      OP_ADD_TRACK: begin
        track_lat_next = cur.latency[22:0];
        if (res.hit) begin
          cmd_next.raise     = 1'b1;
          cmd_next.raise_key = cur.dest_bus_id;
          cmd_next.lat       = cur.latency[22:0];
        end else begin
          if (cur.dest_bus_id != 16'd0) begin
            out_next.status   = ST_TRACK_UNKNOWN;
            out_next.issue_id = cur.item_id;
          end
          if (cur.latency[22:0] > direct_master)
            direct_master_next = cur.latency[22:0];
        end
      end
      OP_ADD_SEND: begin
        if (cur.enabled) begin
          if (cur.dest_bus_id == 16'd0) begin
            out_next.status   = ST_SEND_NO_BUS;
            out_next.issue_id = cur.item_id;
          end else if (!res.hit) begin
            out_next.status   = ST_SEND_UNKNOWN;
            out_next.issue_id = cur.item_id;
          end else begin
            cmd_next.raise     = 1'b1;
            cmd_next.raise_key = cur.dest_bus_id;
            cmd_next.lat       = track_lat;
          end
        end
      end
      OP_FINISH: begin
        pre_master_next        = res.max_tot;
        out_next.total_latency = res.max_tot;
      end
      OP_QUERY_BUS: begin
        out_next.found = res.hit;
        if (res.hit && res.hit_act) begin
          out_next.total_latency = hit_tot;
          if (pre_master > hit_tot) out_next.delay = pre_master - hit_tot;
        end
      end
      OP_QUERY_TRACK: begin
        track_lat_next = cur.latency[22:0];
        if (!res.hit) begin
          out_next.to_master = 1'b1;
          if (pre_master > {1'b0, cur.latency[22:0]})
            out_next.delay = pre_master - {1'b0, cur.latency[22:0]};
        end else if (res.hit_in > cur.latency[22:0]) begin
          out_next.delay = {1'b0, res.hit_in - cur.latency[22:0]};
        end
      end
      OP_QUERY_SEND: begin
        if (cur.enabled && res.hit) begin
          out_next.found = 1'b1;
          if (res.hit_in > track_lat)
            out_next.delay = {1'b0, res.hit_in - track_lat};
        end
      end
      default: ;
    endcase
  end

  // Sequence one item: accept, wait for token, write, report
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      bus_count     <= '0;
      direct_master <= '0;
      pre_master    <= '0;
      track_lat     <= '0;
      cmd           <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          cmd  <= '0;
          if (start) begin
            cur   <= item_c;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          done <= 1'b0;
          if (res.live) begin
            item_out      <= out_next;
            cmd           <= cmd_next;
            direct_master <= direct_master_next;
            pre_master    <= pre_master_next;
            track_lat     <= track_lat_next;
            if (cur.operation == OP_CLEAR) bus_count <= '0;
            state         <= S_WRITE;
          end else begin
            cmd <= '0;
          end
        end
        S_WRITE: begin
          cmd <= '0;
          if (cmd.wr_new) bus_count <= bus_count + 1'b1;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          cmd   <= '0;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== hdl/lcp_checker.sv =====
// Port-level checker for the latency compensation planner, bound to the top.
// Depends on lcp_pkg and latency_compensation_planner_defines.svh.
`timescale 1ns / 1ps
`include "latency_compensation_planner_defines.svh"
module lcp_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input lcp_pkg::lcp_out_t item_out
);
  import lcp_pkg::*;
  `LCP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  `LCP_ASSERT_NEXT(a_done_single, done, !done, "done held over two cycles")
  `LCP_ASSERT_IMP(a_done_frees, done, !busy, "busy still high with done")
  `LCP_ASSERT_IMP(a_status_range, done, item_out.status <= ST_FULL, "status code out of range")
  `LCP_ASSERT_IMP(a_issue_zero, done && item_out.status == ST_OK, item_out.issue_id == 16'd0,
                  "issue id set on ok")
endmodule

bind latency_compensation_planner lcp_checker u_lcp_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .item_out(item_out)
);

// ===== tb/sv/latency_compensation_planner_tb.sv =====
// Self-checking testbench for the latency compensation planner.
// Drives command items from a queue, predicts each result and checks it.
// Depends on lcp_pkg and latency_compensation_planner.
`timescale 1ns / 1ps
module latency_compensation_planner_tb;
  import lcp_pkg::*;

  localparam int TABLE_SIZE = 64;
  localparam int ITEMS_PER_PHASE = 250;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  lcp_in_t  item_in = '0;
  logic     busy;
  logic     done;
  lcp_out_t item_out;

  latency_compensation_planner #(.MAX_BUSES(TABLE_SIZE)) i_dut (
    .clk(clk), .rst(rst), .start(start), .item_in(item_in),
    .busy(busy), .done(done), .item_out(item_out)
  );

  always #10 clk = ~clk;

  lcp_in_t  pending_items[$];
  lcp_out_t expected_results[$];
  int       send_idle_pct = 0;
  int       error_count = 0;
  int       items_sent = 0;
  int       results_seen = 0;
  int       status_seen[8];

  // Planner state mirror
  logic [15:0] bus_ids[TABLE_SIZE];
  logic [22:0] bus_plug[TABLE_SIZE];
  logic [22:0] bus_input[TABLE_SIZE];
  logic        bus_act[TABLE_SIZE];
  int          bus_count = 0;
  logic [22:0] direct_lat = '0;
  logic [23:0] pre_master = '0;
  logic [22:0] track_lat = '0;

  function automatic logic [22:0] clamp_lat(logic signed [23:0] raw);
    return raw[23] ? 23'd0 : raw[22:0];
  endfunction

  function automatic int bus_index(logic [15:0] id);
    if (id == 16'd0) return -1;
    for (int i = 0; i < bus_count; i++)
      if (bus_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [23:0] floor_sub(logic [23:0] a, logic [23:0] b);
    return (a > b) ? a - b : 24'd0;
  endfunction

  function automatic void clear_plan();
    for (int i = 0; i < TABLE_SIZE; i++) begin
      bus_act[i] = 1'b0;
      bus_input[i] = '0;
    end
    bus_count = 0;
    direct_lat = '0;
    pre_master = '0;
    track_lat = '0;
  endfunction

  // Apply one item to the mirror and return the result it causes
  function automatic lcp_out_t plan_item(lcp_in_t it);
    lcp_out_t r;
    logic [22:0] lat;
    logic [23:0] tot;
    int idx;
    r = '0;
    lat = clamp_lat(it.latency);
    case (it.operation)
      OP_CLEAR: begin
        clear_plan();
      end
      OP_ADD_BUS: begin
        if (it.item_id == 16'd0 || bus_index(it.item_id) >= 0) begin
          r.status = ST_BAD_BUS;
          r.issue_id = it.item_id;
        end else if (bus_count >= TABLE_SIZE) begin
          r.status = ST_FULL;
          r.issue_id = it.item_id;
        end else begin
          bus_ids[bus_count] = it.item_id;
          bus_plug[bus_count] = lat;
          bus_input[bus_count] = '0;
          bus_act[bus_count] = 1'b0;
          bus_count++;
        end
      end
      OP_ADD_TRACK: begin
        track_lat = lat;
        idx = bus_index(it.dest_bus_id);
        if (idx < 0) begin
          if (it.dest_bus_id != 16'd0) begin
            r.status = ST_TRACK_UNKNOWN;
            r.issue_id = it.item_id;
          end
          if (lat > direct_lat) direct_lat = lat;
        end else begin
          bus_act[idx] = 1'b1;
          if (lat > bus_input[idx]) bus_input[idx] = lat;
        end
      end
      OP_ADD_SEND: begin
        if (it.enabled) begin
          idx = bus_index(it.dest_bus_id);
          if (it.dest_bus_id == 16'd0) begin
            r.status = ST_SEND_NO_BUS;
            r.issue_id = it.item_id;
          end else if (idx < 0) begin
            r.status = ST_SEND_UNKNOWN;
            r.issue_id = it.item_id;
          end else begin
            bus_act[idx] = 1'b1;
            if (track_lat > bus_input[idx]) bus_input[idx] = track_lat;
          end
        end
      end
      OP_FINISH: begin
        pre_master = {1'b0, direct_lat};
        for (int i = 0; i < bus_count; i++) begin
          tot = {1'b0, bus_input[i]} + {1'b0, bus_plug[i]};
          if (bus_act[i] && tot > pre_master) pre_master = tot;
        end
        r.total_latency = pre_master;
      end
      OP_QUERY_BUS: begin
        idx = bus_index(it.item_id);
        if (idx >= 0) begin
          r.found = 1'b1;
          if (bus_act[idx]) begin
            tot = {1'b0, bus_input[idx]} + {1'b0, bus_plug[idx]};
            r.total_latency = tot;
            r.delay = floor_sub(pre_master, tot);
          end
        end
      end
      OP_QUERY_TRACK: begin
        track_lat = lat;
        idx = bus_index(it.dest_bus_id);
        if (idx < 0) begin
          r.to_master = 1'b1;
          r.delay = floor_sub(pre_master, {1'b0, lat});
        end else begin
          r.delay = floor_sub({1'b0, bus_input[idx]}, {1'b0, lat});
        end
      end
      default: begin
        idx = bus_index(it.dest_bus_id);
        if (it.enabled && idx >= 0) begin
          r.found = 1'b1;
          r.delay = floor_sub({1'b0, bus_input[idx]}, {1'b0, track_lat});
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
    error_count++;
    $display("%0t mismatch in %s: expected %0h, got %0h", $realtime, field, exp_v, got_v);
  endtask

  task automatic push_item(logic [2:0] op, logic [15:0] id, logic [15:0] dest,
                           logic signed [23:0] lat, logic en);
    lcp_in_t it;
    it.operation = op;
    it.item_id = id;
    it.dest_bus_id = dest;
    it.latency = lat;
    it.enabled = en;
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic logic [15:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'd0;
    if (r < 80) return 16'($urandom_range(1, 24));
    if (r < 85) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic signed [23:0] pick_lat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 24'($urandom_range(0, 4000));
    if (r < 80) return -24'sd1 - 24'($urandom_range(0, 2000));
    if (r < 85) return 24'sh7FFFFF;
    if (r < 88) return 24'sh800000;
    return 24'($urandom);
  endfunction

  // Build one routing session: buses, tracks and sends, finish, then queries
  task automatic push_session(bit fill_table);
    int n;
    if ($urandom_range(0, 2) == 0) push_item(OP_CLEAR, 16'($urandom), 16'($urandom),
                                             24'($urandom), 1'($urandom));
    if (fill_table) begin
      push_item(OP_CLEAR, '0, '0, '0, 1'b0);
      for (int i = 0; i < TABLE_SIZE + 2; i++)
        push_item(OP_ADD_BUS, 16'(i + 1), '0, 24'($urandom_range(0, 300)), 1'b0);
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) push_item(OP_ADD_BUS, pick_id(), pick_id(), pick_lat(), 1'b0);
    end
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      push_item(OP_ADD_TRACK, 16'($urandom), pick_id(), pick_lat(), 1'($urandom));
      repeat ($urandom_range(0, 2))
        push_item(OP_ADD_SEND, 16'($urandom), pick_id(), 24'($urandom),
                  1'($urandom_range(0, 9) != 0));
    end
    if ($urandom_range(0, 9) != 0) push_item(OP_FINISH, 16'($urandom), 16'($urandom),
                                             24'($urandom), 1'($urandom));
    n = $urandom_range(2, 7);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: push_item(OP_QUERY_BUS, pick_id(), 16'($urandom), 24'($urandom), 1'($urandom));
        1: push_item(OP_QUERY_TRACK, 16'($urandom), pick_id(), pick_lat(), 1'($urandom));
        2: push_item(OP_QUERY_SEND, 16'($urandom), pick_id(), 24'($urandom),
                     1'($urandom_range(0, 5) != 0));
        default: push_item(3'($urandom), 16'($urandom), 16'($urandom),
                           24'($urandom), 1'($urandom));
      endcase
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Driver: predict accepted items, present the next one after random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.insert(expected_results.size(), plan_item(item_in));
        items_sent++;
      end
      if (!start || !busy) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item_in <= pending_items.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    lcp_out_t exp_r;
    if (!rst && done) begin
      results_seen++;
      status_seen[item_out.status]++;
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t result with no item outstanding", $realtime);
      end else begin
        exp_r = expected_results.pop_front();
        if (item_out.status !== exp_r.status)
          report_mismatch("status", 32'(exp_r.status), 32'(item_out.status));
        if (item_out.issue_id !== exp_r.issue_id)
          report_mismatch("issue_id", 32'(exp_r.issue_id), 32'(item_out.issue_id));
        if (item_out.delay !== exp_r.delay)
          report_mismatch("delay", 32'(exp_r.delay), 32'(item_out.delay));
        if (item_out.total_latency !== exp_r.total_latency)
          report_mismatch("total_latency", 32'(exp_r.total_latency),
                          32'(item_out.total_latency));
        if (item_out.to_master !== exp_r.to_master)
          report_mismatch("to_master", 32'(exp_r.to_master), 32'(item_out.to_master));
        if (item_out.found !== exp_r.found)
          report_mismatch("found", 32'(exp_r.found), 32'(item_out.found));
      end
    end
  end

  // Stimulus
  initial begin
    int pct[3];
    pct[0] = 18;
    pct[1] = 77;
    pct[2] = 0;
    clear_plan();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: error codes, field extremes and every operation
    send_idle_pct = 18;
    push_item(OP_QUERY_TRACK, 16'd5, 16'd0, 24'sd100, 1'b0);
    push_item(OP_ADD_BUS, 16'd0, 16'd0, 24'sd10, 1'b0);
    push_item(OP_ADD_BUS, 16'hFFFF, 16'hFFFF, 24'sh7FFFFF, 1'b1);
    push_item(OP_ADD_BUS, 16'hFFFF, 16'd0, 24'sd5, 1'b0);
    push_item(OP_ADD_BUS, 16'd1, 16'd0, 24'sh800000, 1'b0);
    push_item(OP_ADD_BUS, 16'd2, 16'd0, -24'sd1, 1'b0);
    push_item(OP_ADD_TRACK, 16'hFFFF, 16'd0, 24'sd300, 1'b0);
    push_item(OP_ADD_TRACK, 16'd7, 16'd1, 24'sh7FFFFF, 1'b1);
    push_item(OP_ADD_TRACK, 16'd8, 16'h1234, 24'sd50, 1'b0);
    push_item(OP_ADD_SEND, 16'd9, 16'd0, 24'sd0, 1'b0);
    push_item(OP_ADD_SEND, 16'd10, 16'd0, 24'sd0, 1'b1);
    push_item(OP_ADD_SEND, 16'hFFFF, 16'h4321, 24'sd0, 1'b1);
    push_item(OP_ADD_TRACK, 16'd11, 16'd0, 24'sh800000, 1'b0);
    push_item(OP_ADD_SEND, 16'd12, 16'hFFFF, 24'sd0, 1'b1);
    push_item(OP_QUERY_BUS, 16'd1, 16'd0, 24'sd0, 1'b0);
    push_item(OP_FINISH, 16'd0, 16'd0, 24'sd0, 1'b0);
    push_item(OP_QUERY_BUS, 16'hFFFF, 16'd0, 24'sd0, 1'b0);
    push_item(OP_QUERY_BUS, 16'd2, 16'd0, 24'sd0, 1'b0);
    push_item(OP_QUERY_BUS, 16'd99, 16'd0, 24'sd0, 1'b0);
    push_item(OP_QUERY_TRACK, 16'd1, 16'd1, -24'sd7, 1'b0);
    push_item(OP_QUERY_TRACK, 16'd1, 16'h5555, 24'sd20, 1'b0);
    push_item(OP_QUERY_SEND, 16'd1, 16'hFFFF, 24'sd0, 1'b1);
    push_item(OP_QUERY_SEND, 16'd1, 16'hFFFF, 24'sd0, 1'b0);
    push_item(OP_QUERY_SEND, 16'd1, 16'd77, 24'sd0, 1'b1);
    push_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 24'sh7FFFFF, 1'b1);
    // Hold the sender until every expected result is back
    wait_drained();

    // Random sessions under three idle profiles
    for (int ph = 0; ph < 3; ph++) begin
      int base;
      send_idle_pct = pct[ph];
      base = items_sent;
      push_session(1'b1);
      while (items_sent + pending_items.size() - base < ITEMS_PER_PHASE) begin
        push_session(1'b0);
        while (pending_items.size() > 8) @(posedge clk);
      end
      wait_drained();
    end

    if (expected_results.size() != 0) begin
      error_count += expected_results.size();
      $display("%0d results never arrived", expected_results.size());
    end
    $display("Covered %0d items and %0d results under three sender idle profiles;",
             items_sent, results_seen);
    $display("status counts ok/bad/track/send/nobus/full: %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (error_count == 0) begin
      $display("[latency_compensation_planner] OK");
    end else begin
      $display("[latency_compensation_planner] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("[latency_compensation_planner] ERROR");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/lcp_pkg.sv
hdl/lcp_cell.sv
hdl/latency_compensation_planner.sv
hdl/lcp_checker.sv
tb/sv/latency_compensation_planner_tb.sv
